/* src/named_multi_queue_mailbox_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mailbox block
// Shared concurrent check forms, clocked and disabled by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef NAMED_MULTI_QUEUE_MAILBOX_TOP_ASSERT_SVH
`define NAMED_MULTI_QUEUE_MAILBOX_TOP_ASSERT_SVH

// Condition holds at every edge outside reset.
`define MQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/nmqm_pkg.sv */
// ----------------------------------------------------------------------------
// Mailbox package
// Field widths, operation and status codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package nmqm_pkg;

    localparam int QUEUE_SLOTS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NAME_BYTES_DEF  = 8;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 64;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN    = 3'd0,
        OP_CLOSE   = 3'd1,
        OP_SEND    = 3'd2,
        OP_RECEIVE = 3'd3,
        OP_PENDING = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_NO_SLOT   = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_LOOKUP,
        S_EXEC,
        S_FETCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic match;
        logic lookup;
        logic exec;
        logic fetch;
    } t_cmd;

    typedef struct packed {
        logic need_fetch;
    } t_dp_sts;

    typedef struct packed {
        logic [KEY_W-1:0] sender;
        logic [PAY_W-1:0] payload;
    } t_msg;

endpackage

/* src/nmqm_if.sv */
// ----------------------------------------------------------------------------
// Mailbox channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nmqm_req_if;
    import nmqm_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] queue_key;
    logic [KEY_W-1:0] sender_key;
    logic [PAY_W-1:0] payload;

    modport source (output valid, output op, output queue_key, output sender_key,
                    output payload, input ready);
    modport sink   (input valid, input op, input queue_key, input sender_key,
                    input payload, output ready);
endinterface

interface nmqm_rsp_if;
    import nmqm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    msg_sender;
    logic [PAY_W-1:0]    msg_payload;
    logic [COUNT_W-1:0]  pending_count;

    modport source (output valid, output status, output msg_sender, output msg_payload,
                    output pending_count, input ready);
    modport sink   (input valid, input status, input msg_sender, input msg_payload,
                    input pending_count, output ready);
endinterface

/* src/nmqm_ctrl.sv */
// ----------------------------------------------------------------------------
// Mailbox controller
// Sequences one request word through match, lookup, execute and, for a receive that pops a message, fetch.
// ----------------------------------------------------------------------------
`include "named_multi_queue_mailbox_top_assert.svh"

module nmqm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  nmqm_pkg::t_dp_sts i_sts,
    output nmqm_pkg::t_cmd    o_cmd
);
    import nmqm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // hold ready low while reset is applied
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_fetch ? S_FETCH : S_DONE;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `MQ_ASSERT_ALWAYS(a_one_side, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "ready with result pending")
    `MQ_ASSERT_IMP(a_exec_lat, i_clk, i_rst_n, r_state == S_EXEC, $past(o_in_ready && i_in_valid, 3), "execute without accepted word")
    `MQ_ASSERT_IMP(a_fetch_src, i_clk, i_rst_n, r_state == S_FETCH, $past(i_sts.need_fetch), "fetch without receive")

endmodule

/* src/nmqm_dp.sv */
// ----------------------------------------------------------------------------
// Mailbox datapath
// Slot key table, per-slot ring pointers and the message store.
// ----------------------------------------------------------------------------
`include "named_multi_queue_mailbox_top_assert.svh"

module nmqm_dp #(
    parameter int QUEUE_SLOTS = nmqm_pkg::QUEUE_SLOTS_DEF,
    parameter int QUEUE_DEPTH = nmqm_pkg::QUEUE_DEPTH_DEF,
    parameter int NAME_BYTES  = nmqm_pkg::NAME_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  nmqm_pkg::t_cmd                   i_cmd,
    output nmqm_pkg::t_dp_sts                o_sts,
    input  logic [nmqm_pkg::OP_W-1:0]        i_op,
    input  logic [nmqm_pkg::KEY_W-1:0]       i_queue_key,
    input  logic [nmqm_pkg::KEY_W-1:0]       i_sender_key,
    input  logic [nmqm_pkg::PAY_W-1:0]       i_payload,
    output logic [nmqm_pkg::STATUS_W-1:0]    o_status,
    output logic [nmqm_pkg::KEY_W-1:0]       o_msg_sender,
    output logic [nmqm_pkg::PAY_W-1:0]       o_msg_payload,
    output logic [nmqm_pkg::COUNT_W-1:0]     o_pending_count
);
    import nmqm_pkg::*;

    localparam int SW    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = $clog2(QUEUE_SLOTS * QUEUE_DEPTH);
    localparam int WORDS = QUEUE_SLOTS * QUEUE_DEPTH;
    localparam logic [KEY_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {KEY_W{1'b1}} :
                                             ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
    localparam logic [CW-1:0]    DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [PW:0]      DEPTH_S   = (PW + 1)'(QUEUE_DEPTH);

    typedef struct packed {
        logic [PW-1:0] wptr;
        logic [PW-1:0] rptr;
        logic [CW-1:0] cnt;
    } t_meta;

    // request word
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_sender;
    logic [PAY_W-1:0] r_payload;

    // slot table
    logic [QUEUE_SLOTS-1:0] r_active;
    logic [KEY_W-1:0]       r_slot_key [QUEUE_SLOTS];
    logic [QUEUE_SLOTS-1:0] r_match;

    // lookup result
    logic [SW-1:0] enc_slot;
    logic [SW-1:0] enc_free;
    logic          enc_hit;
    logic          enc_any_free;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_free;
    logic          r_hit;
    logic          r_any_free;

    // ring pointers and message store
    t_meta r_meta_mem [QUEUE_SLOTS];
    t_meta r_meta;
    t_msg  r_store_mem [WORDS];
    t_msg  r_store_rd;

    // execute decode
    t_status       x_status;
    logic [CW-1:0] x_cnt;
    logic          meta_we;
    logic [SW-1:0] meta_wa;
    t_meta         meta_wd;
    logic          store_we;
    logic          store_re;
    logic [AW-1:0] store_addr;
    logic          act_set;
    logic          act_clr;
    logic          need_fetch;
    logic [PW-1:0] ring_wnext;
    logic [PW-1:0] ring_rnext;
    logic [PW-1:0] ring_ptr;
    logic [PW:0]   ring_sum;
    logic [PW-1:0] ring_end;

    // result register
    logic [STATUS_W-1:0] r_status;
    logic [KEY_W-1:0]    r_msg_sender;
    logic [PAY_W-1:0]    r_msg_payload;
    logic [COUNT_W-1:0]  r_pending_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_key     <= i_queue_key & NAME_MASK;
            r_sender  <= i_sender_key & NAME_MASK;
            r_payload <= i_payload;
        end
    end

    // compare every slot against the key in parallel
    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            for (int i = 0; i < QUEUE_SLOTS; i++) begin
                r_match[i] <= r_active[i] && (r_slot_key[i] == r_key);
            end
        end
    end

    // lowest matching slot and lowest free slot
    always_comb begin
        enc_slot     = '0;
        enc_hit      = 1'b0;
        enc_free     = '0;
        enc_any_free = 1'b0;
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                enc_slot = SW'(i);
                enc_hit  = 1'b1;
            end
            if (!r_active[i]) begin
                enc_free     = SW'(i);
                enc_any_free = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_slot     <= enc_slot;
            r_hit      <= enc_hit;
            r_free     <= enc_free;
            r_any_free <= enc_any_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && meta_we) begin
            r_meta_mem[meta_wa] <= meta_wd;
        end
        if (i_cmd.lookup) begin
            r_meta <= r_meta_mem[enc_slot];
        end
    end

    assign ring_wnext = ((PW + 1)'(r_meta.wptr) + 1'b1 >= DEPTH_S) ? '0 : r_meta.wptr + 1'b1;
    assign ring_rnext = ((PW + 1)'(r_meta.rptr) + 1'b1 >= DEPTH_S) ? '0 : r_meta.rptr + 1'b1;
    assign ring_ptr   = (r_op == OP_SEND) ? r_meta.wptr : r_meta.rptr;
    assign store_addr = AW'(AW'(r_slot) * AW'(QUEUE_DEPTH) + AW'(ring_ptr));

    always_comb begin
        x_status   = ST_OK;
        x_cnt      = '0;
        meta_we    = 1'b0;
        meta_wa    = r_slot;
        meta_wd    = r_meta;
        store_we   = 1'b0;
        store_re   = 1'b0;
        act_set    = 1'b0;
        act_clr    = 1'b0;
        need_fetch = 1'b0;
        unique case (r_op)
            OP_OPEN: begin
                if (r_hit) begin
                    x_cnt = r_meta.cnt;
                end else if (r_any_free) begin
                    act_set = 1'b1;
                    meta_we = 1'b1;
                    meta_wa = r_free;
                    meta_wd = '0;
                end else begin
                    x_status = ST_NO_SLOT;
                end
            end
            OP_CLOSE: begin
                if (r_hit) begin
                    act_clr = 1'b1;
                end else begin
                    x_status = ST_NOT_FOUND;
                end
            end
            OP_SEND: begin
                if (!r_hit) begin
                    x_status = ST_NOT_FOUND;
                end else if (r_meta.cnt >= DEPTH_C) begin
                    x_status = ST_FULL;
                    x_cnt    = r_meta.cnt;
                end else begin
                    store_we     = 1'b1;
                    meta_we      = 1'b1;
                    meta_wd.wptr = ring_wnext;
                    meta_wd.cnt  = r_meta.cnt + 1'b1;
                    x_cnt        = r_meta.cnt + 1'b1;
                end
            end
            OP_RECEIVE: begin
                if (!r_hit) begin
                    x_status = ST_NOT_FOUND;
                end else if (r_meta.cnt == '0) begin
                    x_status = ST_EMPTY;
                end else begin
                    store_re     = 1'b1;
                    need_fetch   = 1'b1;
                    meta_we      = 1'b1;
                    meta_wd.rptr = ring_rnext;
                    meta_wd.cnt  = r_meta.cnt - 1'b1;
                    x_cnt        = r_meta.cnt - 1'b1;
                end
            end
            OP_PENDING: begin
                if (r_hit) begin
                    x_cnt = r_meta.cnt;
                end else begin
                    x_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.need_fetch = need_fetch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.exec) begin
            if (act_set) begin
                r_active[r_free] <= 1'b1;
            end
            if (act_clr) begin
                r_active[r_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && act_set) begin
            r_slot_key[r_free] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && store_we) begin
            r_store_mem[store_addr] <= {r_sender, r_payload};
        end
        if (i_cmd.exec && store_re) begin
            r_store_rd <= r_store_mem[store_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status        <= x_status;
            r_msg_sender    <= '0;
            r_msg_payload   <= '0;
            r_pending_count <= COUNT_W'(x_cnt);
        end else if (i_cmd.fetch) begin
            r_msg_sender  <= r_store_rd.sender;
            r_msg_payload <= r_store_rd.payload;
        end
    end

    assign o_status        = r_status;
    assign o_msg_sender    = r_msg_sender;
    assign o_msg_payload   = r_msg_payload;
    assign o_pending_count = r_pending_count;

    // read pointer plus fill count lands on the write pointer
    assign ring_sum = (PW + 1)'(r_meta.rptr) + (PW + 1)'(r_meta.cnt);
    assign ring_end = (ring_sum >= DEPTH_S) ? PW'(ring_sum - DEPTH_S) : PW'(ring_sum);

    `MQ_ASSERT_IMP(a_key_unique, i_clk, i_rst_n, i_cmd.lookup, $onehot0(r_match), "two slots hold one key")
    `MQ_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, i_cmd.exec && r_hit, r_meta.cnt <= DEPTH_C, "fill count past depth")
    `MQ_ASSERT_IMP(a_ring_agree, i_clk, i_rst_n, i_cmd.exec && r_hit, ring_end == r_meta.wptr, "ring pointers disagree with fill count")

endmodule

/* src/named_multi_queue_mailbox_top.sv */
// ----------------------------------------------------------------------------
// Named multi-queue mailbox
// A table of message queues found by name key, each a ring of sender and
// payload words, served one request word at a time.
// ----------------------------------------------------------------------------
//  Channel   Dir  Words carried
//  i_req     in   op, queue_key, sender_key, payload
//  o_rsp     out  status, msg_sender, msg_payload, pending_count
//
//  A response word is valid once its request word is taken and has passed
//  the slot compare, the encode and pointer read, and execute, and for a
//  receive that pops a message, the message store read as well.
//  One word is in flight; the next is taken the cycle after the response.
//  Reset clears the slot flags at once; a stalled response holds until taken.
// ----------------------------------------------------------------------------
module named_multi_queue_mailbox_top #(
    parameter int QUEUE_SLOTS = nmqm_pkg::QUEUE_SLOTS_DEF,
    parameter int QUEUE_DEPTH = nmqm_pkg::QUEUE_DEPTH_DEF,
    parameter int NAME_BYTES  = nmqm_pkg::NAME_BYTES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    nmqm_req_if.sink   i_req,
    nmqm_rsp_if.source o_rsp
);
    import nmqm_pkg::*;

    t_cmd    cmd;
    t_dp_sts sts;

    // Sequence each word: accept, compare keys, encode and read pointers,
    // execute, fetch the popped message, then hold the result.
    nmqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Slot keys, ring pointers, message store and the response register.
    nmqm_dp #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_req.op),
        .i_queue_key     (i_req.queue_key),
        .i_sender_key    (i_req.sender_key),
        .i_payload       (i_req.payload),
        .o_status        (o_rsp.status),
        .o_msg_sender    (o_rsp.msg_sender),
        .o_msg_payload   (o_rsp.msg_payload),
        .o_pending_count (o_rsp.pending_count)
    );

endmodule

/* test/tb_named_multi_queue_mailbox_top.sv */
// ----------------------------------------------------------------------------
// Mailbox block testbench
// Drives request words into the named queue table and scores every response
// word against a predictor of slots, rings and status codes. Traffic runs
// through four idling phases after a short set of corner cases.
// ----------------------------------------------------------------------------
module tb_named_multi_queue_mailbox_top;
    import nmqm_pkg::*;

    localparam int SLOTS      = QUEUE_SLOTS_DEF;
    localparam int DEPTH      = QUEUE_DEPTH_DEF;
    localparam int NAME_BYTES = NAME_BYTES_DEF;
    localparam logic [KEY_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    // Codes above the pending count carry no operation
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam int POOL_NAMES    = 11;   // more names than slots, so slots run out
    localparam int TRAFFIC_WORDS = 300;  // per idling phase
    localparam int TAIL_CYCLES   = 12;   // idle tail after the last response
    localparam int RUN_LIMIT     = 2_000_000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    sender;
        logic [PAY_W-1:0]    payload;
        logic [COUNT_W-1:0]  count;
    } t_reply;

    logic clk = 1'b0;
    logic rst_n;

    nmqm_req_if req_if ();
    nmqm_rsp_if rsp_if ();

    named_multi_queue_mailbox_top #(
        .QUEUE_SLOTS (SLOTS),
        .QUEUE_DEPTH (DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Mirror of the queue table: slot flags, names, ring pointers and fill
    logic             slot_open [SLOTS];
    logic [KEY_W-1:0] slot_name [SLOTS];
    int               tail_idx  [SLOTS];
    int               head_idx  [SLOTS];
    int               slot_fill [SLOTS];
    logic [KEY_W-1:0] ring_sender  [SLOTS*DEPTH];
    logic [PAY_W-1:0] ring_payload [SLOTS*DEPTH];

    t_reply           replies_due [$];
    logic [KEY_W-1:0] name_pool [POOL_NAMES];

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int error_count   = 0;
    int words_checked = 0;
    int seen_full     = 0;
    int seen_no_slot  = 0;
    int seen_empty    = 0;
    int seen_missing  = 0;

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int ring_step(int p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    // Apply one request to the mirrored table and return the response word
    // it must produce.
    function automatic t_reply apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] qkey,
                                             logic [KEY_W-1:0] skey, logic [PAY_W-1:0] pay);
        t_reply           r;
        logic [KEY_W-1:0] name;
        int               hit_slot;
        int               free_slot;
        int               addr;
        int               i;
        r         = '0;
        r.status  = ST_OK;
        name      = qkey & NAME_MASK;
        hit_slot  = -1;
        free_slot = -1;
        // Walk downwards so the lowest index wins
        for (i = SLOTS - 1; i >= 0; i--) begin
            if (slot_open[i] && slot_name[i] == name) hit_slot = i;
            if (!slot_open[i]) free_slot = i;
        end
        case (op)
            OP_OPEN: begin
                if (hit_slot >= 0) begin
                    r.count = COUNT_W'(slot_fill[hit_slot]);
                end else if (free_slot < 0) begin
                    r.status = ST_NO_SLOT;
                end else begin
                    slot_open[free_slot] = 1'b1;
                    slot_name[free_slot] = name;
                    tail_idx[free_slot]  = 0;
                    head_idx[free_slot]  = 0;
                    slot_fill[free_slot] = 0;
                end
            end
            OP_CLOSE: begin
                if (hit_slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    slot_open[hit_slot] = 1'b0;
                    tail_idx[hit_slot]  = 0;
                    head_idx[hit_slot]  = 0;
                    slot_fill[hit_slot] = 0;
                end
            end
            OP_SEND: begin
                if (hit_slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (slot_fill[hit_slot] >= DEPTH) begin
                    r.status = ST_FULL;
                    r.count  = COUNT_W'(slot_fill[hit_slot]);
                end else begin
                    addr               = hit_slot * DEPTH + tail_idx[hit_slot];
                    ring_sender[addr]  = skey & NAME_MASK;
                    ring_payload[addr] = pay;
                    tail_idx[hit_slot] = ring_step(tail_idx[hit_slot]);
                    slot_fill[hit_slot]++;
                    r.count = COUNT_W'(slot_fill[hit_slot]);
                end
            end
            OP_RECEIVE: begin
                if (hit_slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (slot_fill[hit_slot] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    addr               = hit_slot * DEPTH + head_idx[hit_slot];
                    r.sender           = ring_sender[addr];
                    r.payload          = ring_payload[addr];
                    head_idx[hit_slot] = ring_step(head_idx[hit_slot]);
                    slot_fill[hit_slot]--;
                    r.count = COUNT_W'(slot_fill[hit_slot]);
                end
            end
            OP_PENDING: begin
                if (hit_slot < 0) r.status = ST_NOT_FOUND;
                else r.count = COUNT_W'(slot_fill[hit_slot]);
            end
            default: ;  // spare codes leave the table alone and answer zero
        endcase
        return r;
    endfunction

    // Offer one request word, idling first at the phase's rate, and hold it
    // until the block takes it. Valid stays high afterwards so a following
    // word can go back to back.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] qkey,
                                input logic [KEY_W-1:0] skey, input logic [PAY_W-1:0] pay);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.queue_key  <= qkey;
        req_if.sender_key <= skey;
        req_if.payload    <= pay;
        do @(posedge clk); while (!req_if.ready);
        replies_due.push_back(apply_request(op, qkey, skey, pay));
    endtask

    // Stall the response channel at the phase's rate
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Score each accepted response word against the oldest prediction
    always @(posedge clk) begin : score_replies
        t_reply want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (replies_due.size() == 0) begin
                if (error_count < REPORT_LIMIT)
                    $display("Unrequested response word at %0t: status %0d", $time,
                             rsp_if.status);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                words_checked++;
                case (want.status)
                    ST_FULL:      seen_full++;
                    ST_NO_SLOT:   seen_no_slot++;
                    ST_EMPTY:     seen_empty++;
                    ST_NOT_FOUND: seen_missing++;
                    default: ;
                endcase
                if (rsp_if.status !== want.status || rsp_if.msg_sender !== want.sender ||
                    rsp_if.msg_payload !== want.payload ||
                    rsp_if.pending_count !== want.count) begin
                    if (error_count < REPORT_LIMIT) begin
                        $display("Response mismatch at %0t (expected / actual):", $time);
                        $display("  status %0d / %0d  count %0d / %0d", want.status,
                                 rsp_if.status, want.count, rsp_if.pending_count);
                        $display("  sender %h / %h  payload %h / %h", want.sender,
                                 rsp_if.msg_sender, want.payload, rsp_if.msg_payload);
                    end
                    error_count++;
                end
            end
        end
    end

    // Corner cases: pending, receive, send and close on a missing name, the zero and
    // all-ones names, extreme sender and payload words, a reopen that keeps
    // its messages, a close that drops them, and the spare op codes.
    task automatic test_corner_cases();
        logic [KEY_W-1:0] zero_key;
        logic [KEY_W-1:0] ones_key;
        int               c;
        zero_key = '0;
        ones_key = '1;
        send_request(OP_PENDING, zero_key, '0, '0);
        send_request(OP_RECEIVE, ones_key, '0, '0);
        send_request(OP_SEND,    zero_key, '1, '1);
        send_request(OP_CLOSE,   zero_key, '0, '0);
        send_request(OP_OPEN,    zero_key, '0, '0);
        send_request(OP_OPEN,    ones_key, '0, '0);
        send_request(OP_OPEN,    zero_key, '0, '0);
        send_request(OP_SEND,    zero_key, '1, '1);
        send_request(OP_SEND,    zero_key, '0, '0);
        send_request(OP_OPEN,    zero_key, '0, '0);
        send_request(OP_PENDING, zero_key, '0, '0);
        send_request(OP_RECEIVE, zero_key, '0, '0);
        send_request(OP_RECEIVE, zero_key, '0, '0);
        send_request(OP_RECEIVE, zero_key, '0, '0);
        send_request(OP_SEND,    ones_key, {32{2'b01}}, {16{2'b10}});
        send_request(OP_CLOSE,   ones_key, '0, '0);
        send_request(OP_RECEIVE, ones_key, '0, '0);
        send_request(OP_OPEN,    ones_key, '0, '0);
        send_request(OP_RECEIVE, ones_key, '0, '0);
        for (c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
            send_request(OP_W'(c), zero_key, rand64(), $urandom());
        send_request(OP_CLOSE, zero_key, '0, '0);
        send_request(OP_CLOSE, ones_key, '0, '0);
    endtask

    // Mailbox traffic on a small pool of names: send and receive bursts long
    // enough to fill and drain rings, opens outpacing closes so the table
    // runs out of slots, plus a share of noise with any op and any name.
    task automatic run_traffic(input int words, input int idle_pct, input int stall_pct);
        int               done_words;
        int               choice;
        int               burst;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] qkey;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        done_words    = 0;
        while (done_words < words) begin
            qkey   = name_pool[$urandom_range(POOL_NAMES - 1)];
            choice = $urandom_range(99);
            if (choice < 40) begin
                burst = $urandom_range(20, 1);
                repeat (burst) send_request(OP_SEND, qkey, rand64(), $urandom());
                done_words += burst;
            end else if (choice < 65) begin
                burst = $urandom_range(20, 1);
                repeat (burst) send_request(OP_RECEIVE, qkey, rand64(), $urandom());
                done_words += burst;
            end else if (choice < 80) begin
                send_request(OP_OPEN, qkey, rand64(), $urandom());
                done_words++;
            end else if (choice < 87) begin
                send_request(OP_CLOSE, qkey, rand64(), $urandom());
                done_words++;
            end else if (choice < 94) begin
                send_request(OP_PENDING, qkey, rand64(), $urandom());
                done_words++;
            end else begin
                op = OP_W'($urandom_range(OP_SPARE_LAST));
                if ($urandom_range(1)) qkey = rand64();
                send_request(op, qkey, rand64(), $urandom());
                // spare codes do nothing, so leave them out of the tally
                if (op <= OP_PENDING) done_words++;
            end
        end
    endtask

    task automatic test_traffic_steady();
        run_traffic(TRAFFIC_WORDS, 0, 0);
    endtask

    task automatic test_traffic_sender_gaps();
        run_traffic(TRAFFIC_WORDS, 60, 0);
    endtask

    task automatic test_traffic_receiver_stalls();
        run_traffic(TRAFFIC_WORDS, 0, 60);
    endtask

    task automatic test_traffic_both_idle();
        run_traffic(TRAFFIC_WORDS, 29, 29);
    endtask

    // Drop valid, wait for every predicted word, then let the pipe settle
    task automatic drain_replies();
        req_if.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial begin
        int i;
        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.op         <= OP_OPEN;
        req_if.queue_key  <= '0;
        req_if.sender_key <= '0;
        req_if.payload    <= '0;
        for (i = 0; i < SLOTS; i++) begin
            slot_open[i] = 1'b0;
            slot_name[i] = '0;
            tail_idx[i]  = 0;
            head_idx[i]  = 0;
            slot_fill[i] = 0;
        end
        for (i = 0; i < SLOTS * DEPTH; i++) begin
            ring_sender[i]  = '0;
            ring_payload[i] = '0;
        end
        for (i = 0; i < POOL_NAMES; i++) name_pool[i] = rand64();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        test_traffic_steady();
        test_traffic_sender_gaps();
        test_traffic_receiver_stalls();
        test_traffic_both_idle();
        drain_replies();

        $display("Checked %0d response words over four idling phases;", words_checked);
        $display("  %0d full, %0d no free slot, %0d empty, %0d unknown name",
                 seen_full, seen_no_slot, seen_empty, seen_missing);
        if (error_count == 0 && replies_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(RUN_LIMIT);
        $display("Timed out waiting on the block");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
